/* hdl/mapg_pkg.sv */
package mapg_pkg;

   localparam int BPM_W     = 9;
   localparam int MODE_W    = 4;
   localparam int TLEN_W    = 8;
   localparam int PERIOD_W  = 12;
   localparam int POS_W     = 4;
   localparam int TONE_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;

   // restoring divider: dividend is the constant ms per minute
   localparam int DIVIDEND_W = 16;
   localparam int DIVISOR_W  = 11;
   localparam int DIV_CNT_W  = 4;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

   localparam logic [DIVIDEND_W-1:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [BPM_W-1:0]      BPM_MAX       = 9'd300;
   localparam logic [BPM_W-1:0]      BPM_MIN       = 9'd20;

   localparam logic [BPM_W-1:0]    BPM_RESET    = 9'd60;
   localparam logic [MODE_W-1:0]   MODE_RESET   = 4'd0;
   localparam logic [TLEN_W-1:0]   TLEN_RESET   = 8'd50;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd1000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BPM  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TLEN = 2'd2;

   // tone codes
   localparam logic [TONE_W-1:0] TONE_SILENT = 2'd0;
   localparam logic [TONE_W-1:0] TONE_LOW    = 2'd1;
   localparam logic [TONE_W-1:0] TONE_HIGH   = 2'd2;

   // beat modes
   localparam logic [MODE_W-1:0] MODE_OFF       = 4'd0;
   localparam logic [MODE_W-1:0] MODE_ALL_LOW   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_ALL_HIGH  = 4'd2;
   localparam logic [MODE_W-1:0] MODE_ACCENT_HI = 4'd10;
   localparam logic [MODE_W-1:0] MODE_EIGHTH    = 4'd11;
   localparam logic [MODE_W-1:0] MODE_TRIPLET   = 4'd12;
   localparam logic [MODE_W-1:0] MODE_SPLIT_TRI = 4'd13;
   localparam logic [MODE_W-1:0] MODE_SIXTEENTH = 4'd14;
   localparam logic [MODE_W-1:0] MODE_SPLIT_SIX = 4'd15;

   typedef struct packed {
      logic tick;       // process one millisecond tick, load result
      logic div_start;  // load divisor and dividend
      logic div_step;   // one quotient bit
      logic div_done;   // commit period, clear counters, load result
   } cmd_type;

endpackage

/* hdl/metronome_accent_pattern_generator.sv */
// Results: a tick gives its result in the cycle after its transfer; a restart gives
//    its result after 16 radix-2 divider steps and a commit state.
// Throughput: one tick per cycle when the result side keeps up; a restart holds
//    the input side until the bit-serial period divider has run and committed.
// Reset (synchronous, active high): bpm 60, mode off, tone length 50, period 1000,
//    counters cleared, held tone silent, no result pending.
module metronome_accent_pattern_generator
   import mapg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input items: restart flag or one millisecond tick
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_restart,
   // result items, one per input item
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [TONE_W-1:0]    rsp_tone_code,
   output logic                 rsp_beat_fired,
   // register writes: 0 bpm, 1 beat mode, 2 tone length
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cmd_type cmd;

   // registers are always writable; software writes only while idle
   assign csr_ready = 1'b1;

   // sequencer: accepts items, runs the divider, owns the result valid
   mapg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd)
   );

   // datapath: registers, beat counters, accent pattern, period divider,
   // result payload register
   mapg_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_tone_code  (rsp_tone_code),
      .rsp_beat_fired (rsp_beat_fired)
   );

endmodule

/* hdl/mapg_ctrl.sv */
module mapg_ctrl
   import mapg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_restart,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_xfer;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd.tick      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.div_done  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_restart) begin
                  cmd.div_start = 1'b1;
                  cnt_in        = '0;
                  state_in      = ST_DIV;
               end else begin
                  cmd.tick = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.div_done = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.tick || cmd.div_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_restart_to_div: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_restart) |=> (state_ff == ST_DIV && cnt_ff == '0))
      else $error("restart did not start the divider");

   a_fin_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> !rsp_valid_ff)
      else $error("restart result would overwrite a pending result");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("input taken while divider busy");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == DIV_LAST) |=> (state_ff == ST_FIN))
      else $error("divider step count wrong");

endmodule

/* hdl/mapg_datapath.sv */
module mapg_datapath
   import mapg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output logic [TONE_W-1:0]    rsp_tone_code,
   output logic                 rsp_beat_fired
);

   // tone for the beat at position pos
   function automatic logic [TONE_W-1:0] pick_tone(input logic [MODE_W-1:0] mode,
                                                   input logic [POS_W-1:0]  pos);
      logic [TONE_W-1:0] t;
      begin
         if (mode == MODE_ALL_LOW) begin
            t = TONE_LOW;
         end else if (mode == MODE_ALL_HIGH) begin
            t = TONE_HIGH;
         end else if (mode <= MODE_EIGHTH) begin
            t = (pos == '0) ? TONE_HIGH : TONE_LOW;
         end else if (pos == '0) begin
            t = TONE_HIGH;
         end else if (pos == 4'd1 && (mode == MODE_SPLIT_TRI || mode == MODE_SPLIT_SIX)) begin
            t = TONE_SILENT;
         end else if (pos == 4'd2 && mode == MODE_SPLIT_SIX) begin
            t = TONE_SILENT;
         end else begin
            t = TONE_LOW;
         end
         return t;
      end
   endfunction

   // accent position after a beat, wrapping once past the pattern's last step; all-low and all-high hold it
   function automatic logic [POS_W-1:0] next_pos(input logic [MODE_W-1:0] mode,
                                                 input logic [POS_W-1:0]  pos);
      logic [POS_W-1:0] lim;
      logic [POS_W-1:0] p;
      begin
         if (mode <= MODE_ACCENT_HI) begin
            lim = mode - 4'd2;
         end else if (mode == MODE_EIGHTH) begin
            lim = 4'd1;
         end else if (mode <= MODE_SPLIT_TRI) begin
            lim = 4'd2;
         end else begin
            lim = 4'd3;
         end
         if (mode == MODE_ALL_LOW || mode == MODE_ALL_HIGH) begin
            p = pos;
         end else if (pos >= lim) begin
            p = '0;
         end else begin
            p = pos + 1'b1;
         end
         return p;
      end
   endfunction

   function automatic logic [2:0] subdivision(input logic [MODE_W-1:0] mode);
      logic [2:0] s;
      begin
         case (mode)
            MODE_EIGHTH:                   s = 3'd2;
            MODE_TRIPLET, MODE_SPLIT_TRI:  s = 3'd3;
            MODE_SIXTEENTH, MODE_SPLIT_SIX: s = 3'd4;
            default:                       s = 3'd1;
         endcase
         return s;
      end
   endfunction

   logic [BPM_W-1:0]      bpm_ff, bpm_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [TLEN_W-1:0]     tlen_ff, tlen_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [PERIOD_W-1:0]   elapsed_ff, elapsed_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [TLEN_W-1:0]     remain_ff, remain_in;
   logic [TONE_W-1:0]     held_ff, held_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W-1:0]  drem_ff, drem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [TONE_W-1:0]     tone_out_ff, tone_out_in;
   logic                  fired_out_ff, fired_out_in;

   logic [BPM_W-1:0]      bpm_clamped;
   logic [DIVISOR_W:0]    trial;
   logic                  trial_ge;
   logic                  csr_xfer;
   logic                  fire;

   assign csr_xfer = csr_valid && csr_ready;

   always_comb begin
      bpm_in  = bpm_ff;
      mode_in = mode_ff;
      tlen_in = tlen_ff;
      if (csr_xfer) begin
         case (csr_index)
            CSR_BPM:  bpm_in  = csr_data;
            CSR_MODE: mode_in = csr_data[MODE_W-1:0];
            CSR_TLEN: tlen_in = csr_data[TLEN_W-1:0];
            default:  bpm_in  = bpm_ff;
         endcase
      end
   end

   // (60000 / b) / s == 60000 / (b * s) for positive integers
   always_comb begin
      if (bpm_ff > BPM_MAX) begin
         bpm_clamped = BPM_MAX;
      end else if (bpm_ff < BPM_MIN) begin
         bpm_clamped = BPM_MIN;
      end else begin
         bpm_clamped = bpm_ff;
      end
   end

   assign trial    = {drem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial_ge = trial >= {1'b0, divisor_ff};

   always_comb begin
      divisor_in = divisor_ff;
      drem_in    = drem_ff;
      quo_in     = quo_ff;
      if (cmd.div_start) begin
         divisor_in = DIVISOR_W'({2'b00, bpm_clamped} * {8'd0, subdivision(mode_ff)});
         drem_in    = '0;
         quo_in     = MS_PER_MINUTE;
      end else if (cmd.div_step) begin
         drem_in = trial_ge ? DIVISOR_W'(trial - {1'b0, divisor_ff})
                            : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], trial_ge};
      end
   end

   always_comb begin
      period_in    = period_ff;
      elapsed_in   = elapsed_ff;
      pos_in       = pos_ff;
      remain_in    = remain_ff;
      held_in      = held_ff;
      fire         = 1'b0;
      tone_out_in  = tone_out_ff;
      fired_out_in = fired_out_ff;
      if (cmd.div_done) begin
         period_in    = quo_ff[PERIOD_W-1:0];
         elapsed_in   = '0;
         pos_in       = '0;
         remain_in    = '0;
         held_in      = TONE_SILENT;
         tone_out_in  = TONE_SILENT;
         fired_out_in = 1'b0;
      end else if (cmd.tick) begin
         if (remain_ff != '0) begin
            remain_in = remain_ff - 1'b1;
            if (remain_ff == 8'd1) begin
               held_in = TONE_SILENT;
            end
         end
         if (mode_ff != MODE_OFF) begin
            elapsed_in = elapsed_ff + 1'b1;
            if (elapsed_in >= period_ff) begin
               fire       = 1'b1;
               elapsed_in = '0;
               held_in    = pick_tone(mode_ff, pos_ff);
               pos_in     = next_pos(mode_ff, pos_ff);
               remain_in  = (tlen_ff == '0) ? 8'd1 : tlen_ff;
            end
         end
         tone_out_in  = held_in;
         fired_out_in = fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpm_ff     <= BPM_RESET;
         mode_ff    <= MODE_RESET;
         tlen_ff    <= TLEN_RESET;
         period_ff  <= PERIOD_RESET;
         elapsed_ff <= '0;
         pos_ff     <= '0;
         remain_ff  <= '0;
         held_ff    <= TONE_SILENT;
      end else begin
         bpm_ff     <= bpm_in;
         mode_ff    <= mode_in;
         tlen_ff    <= tlen_in;
         period_ff  <= period_in;
         elapsed_ff <= elapsed_in;
         pos_ff     <= pos_in;
         remain_ff  <= remain_in;
         held_ff    <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff   <= divisor_in;
      drem_ff      <= drem_in;
      quo_ff       <= quo_in;
      tone_out_ff  <= tone_out_in;
      fired_out_ff <= fired_out_in;
   end

   assign rsp_tone_code  = tone_out_ff;
   assign rsp_beat_fired = fired_out_ff;

   a_silent_when_idle: assert property (@(posedge clock) disable iff (reset)
      (remain_ff == '0) |-> (held_ff == TONE_SILENT))
      else $error("tone held with no hold time left");

   a_fire_reload: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick && fire) |=> (remain_ff != '0 && elapsed_ff == '0))
      else $error("beat did not restart the hold");

   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      cmd.div_done |=> (rsp_tone_code == TONE_SILENT && !rsp_beat_fired))
      else $error("restart result not silent");

endmodule
